/* rtl/core/sas_pkg.sv */
`default_nettype none

package sas_pkg;

    localparam int KIND_W       = 2;
    localparam int VALUE_W      = 32;
    localparam int INDEX_W      = 4;
    localparam int STATUS_W     = 2;
    localparam int COUNT_W      = 5;
    localparam int CAP_W        = 5;
    localparam int IN_TDATA_W   = 40;
    localparam int OUT_TDATA_W  = 40;
    localparam int INDEX_SPAN   = 1 << INDEX_W;

    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ   = 2'd2;

    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef struct packed {
        logic load;
        logic exec;
        logic cfg_we;
    } sas_cmd_t;

endpackage

`default_nettype wire

/* rtl/core/sas_ctrl.sv */
`default_nettype none

module sas_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  wire logic             out_ready,
    input  wire logic             cfg_valid,
    output sas_pkg::sas_cmd_t     cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd.load       = 1'b0;
        cmd.exec       = 1'b0;
        cmd.cfg_we     = cfg_valid;
        in_ready       = 1'b0;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.exec       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

/* rtl/core/sas_datapath.sv */
`default_nettype none

module sas_datapath #(
    parameter int DEPTH      = 16,
    parameter int VALUE_BITS = 32
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire sas_pkg::sas_cmd_t               cmd,
    input  wire logic [sas_pkg::KIND_W-1:0]      in_kind,
    input  wire logic [sas_pkg::VALUE_W-1:0]     in_value,
    input  wire logic [sas_pkg::INDEX_W-1:0]     in_index,
    input  wire logic [sas_pkg::CAP_W-1:0]       cfg_capacity,
    output logic [sas_pkg::VALUE_W-1:0]          res_read_value,
    output logic [sas_pkg::STATUS_W-1:0]         res_status,
    output logic [sas_pkg::COUNT_W-1:0]          res_count
);

    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > sas_pkg::CAP_W) ? CW : sas_pkg::CAP_W;
    localparam int RDN  = (DEPTH < sas_pkg::INDEX_SPAN) ? DEPTH : sas_pkg::INDEX_SPAN;

    logic [VALUE_BITS-1:0]           ent_reg [DEPTH];
    logic [VALUE_BITS-1:0]           ent_ins [DEPTH];
    logic [VALUE_BITS-1:0]           ent_del [DEPTH];
    logic [CW-1:0]                   count_reg;
    logic [CW-1:0]                   count_next;
    logic [sas_pkg::CAP_W-1:0]       cap_reg;
    logic [sas_pkg::KIND_W-1:0]      kind_reg;
    logic [VALUE_BITS-1:0]           value_reg;
    logic [sas_pkg::INDEX_W-1:0]     index_reg;
    logic [sas_pkg::VALUE_W-1:0]     rd_value_reg;
    logic [sas_pkg::VALUE_W-1:0]     rd_value_next;
    logic [sas_pkg::STATUS_W-1:0]    status_reg;
    logic [sas_pkg::STATUS_W-1:0]    status_next;
    logic [sas_pkg::COUNT_W-1:0]     res_count_reg;
    logic [DEPTH-1:0]                gt;
    logic [CMPW-1:0]                 cnt_ext;
    logic [CMPW-1:0]                 cap_eff;
    logic [CMPW-1:0]                 idx_ext;
    logic [CMPW-1:0]                 cnt_next_ext;
    logic                            full;
    logic                            in_range;
    logic                            do_ins;
    logic                            do_del;
    logic [VALUE_BITS-1:0]           rd_mux;

    always_comb
    begin
        cnt_ext  = CMPW'(count_reg);
        idx_ext  = CMPW'(index_reg);
        cap_eff  = (cap_reg == '0) ? CMPW'(1) : CMPW'(cap_reg);
        full     = (cnt_ext >= cap_eff) || (cnt_ext >= CMPW'(DEPTH));
        in_range = idx_ext < cnt_ext;

        // Slots at or past the count count as greater, so the compare vector is monotone.
        for (int i = 0; i < DEPTH; i++)
        begin
            gt[i] = (CMPW'(i) >= cnt_ext) ? 1'b1 : (value_reg < ent_reg[i]);
        end

        ent_ins[0] = gt[0] ? value_reg : ent_reg[0];
        for (int i = 1; i < DEPTH; i++)
        begin
            if (gt[i])
            begin
                ent_ins[i] = gt[i-1] ? ent_reg[i-1] : value_reg;
            end
            else
            begin
                ent_ins[i] = ent_reg[i];
            end
        end

        for (int i = 0; i < DEPTH - 1; i++)
        begin
            ent_del[i] = (CMPW'(i) >= idx_ext) ? ent_reg[i+1] : ent_reg[i];
        end
        ent_del[DEPTH-1] = ent_reg[DEPTH-1];

        rd_mux = '0;
        for (int i = 0; i < RDN; i++)
        begin
            if (index_reg == sas_pkg::INDEX_W'(i))
            begin
                rd_mux = ent_reg[i];
            end
        end

        do_ins        = 1'b0;
        do_del        = 1'b0;
        count_next    = count_reg;
        rd_value_next = '0;
        status_next   = sas_pkg::ST_DONE;
        case (kind_reg)
            sas_pkg::KIND_INSERT:
            begin
                if (full)
                begin
                    status_next = sas_pkg::ST_FULL;
                end
                else
                begin
                    do_ins     = 1'b1;
                    count_next = CW'(count_reg + 1'b1);
                end
            end
            sas_pkg::KIND_DELETE:
            begin
                if (in_range)
                begin
                    do_del     = 1'b1;
                    count_next = CW'(count_reg - 1'b1);
                end
                else
                begin
                    status_next = sas_pkg::ST_RANGE;
                end
            end
            sas_pkg::KIND_READ:
            begin
                if (in_range)
                begin
                    rd_value_next = sas_pkg::VALUE_W'(rd_mux);
                end
                else
                begin
                    status_next = sas_pkg::ST_RANGE;
                end
            end
            default:
            begin
                status_next = sas_pkg::ST_DONE;
            end
        endcase
        cnt_next_ext = CMPW'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            cap_reg   <= sas_pkg::CAP_RESET;
        end
        else
        begin
            if (cmd.exec)
            begin
                count_reg <= count_next;
            end
            if (cmd.cfg_we)
            begin
                cap_reg <= cfg_capacity;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg  <= in_kind;
            value_reg <= VALUE_BITS'(in_value);
            index_reg <= in_index;
        end
        if (cmd.exec)
        begin
            rd_value_reg  <= rd_value_next;
            status_reg    <= status_next;
            res_count_reg <= cnt_next_ext[sas_pkg::COUNT_W-1:0];
            for (int i = 0; i < DEPTH; i++)
            begin
                if (do_ins)
                begin
                    ent_reg[i] <= ent_ins[i];
                end
                else if (do_del)
                begin
                    ent_reg[i] <= ent_del[i];
                end
            end
        end
    end

    assign res_read_value = rd_value_reg;
    assign res_status     = status_reg;
    assign res_count      = res_count_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        CMPW'(count_reg) <= CMPW'(DEPTH))
        else $error("entry count exceeds depth");

    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.exec |=> $stable(count_reg))
        else $error("entry count changed without an operation");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |=> (count_reg == $past(count_reg)
                   || count_reg == $past(count_reg) + 1'b1
                   || count_reg == $past(count_reg) - 1'b1))
        else $error("entry count moved by more than one");

    a_sorted_head: assert property (@(posedge clk) disable iff (!rst_n)
        (CMPW'(count_reg) >= CMPW'(2)) |-> (ent_reg[0] <= ent_reg[1]))
        else $error("first two entries out of order");
`endif

endmodule

`default_nettype wire

/* rtl/core/sorted_array_store_top.sv */
`default_nettype none

// Channel   Direction  Handshake                      Payload
// s_axis    in         s_axis_tvalid / s_axis_tready  tuser: kind; tdata: value, index
// m_axis    out        m_axis_tvalid / m_axis_tready  tuser: status; tdata: read_value, count
// cfg       in         cfg_valid / cfg_ready          cfg_data: capacity
//
// Each transaction first captures the operation, then compares and shifts all
// entries in parallel and loads the result register.
// The result register lets a new transaction be captured while a result waits.
// A stalled result holds the operation in the execute state until it is taken.
// Reset empties the store and sets the capacity to sixteen.

module sorted_array_store_top #(
    parameter int DEPTH      = 16,
    parameter int VALUE_BITS = 32
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // [31:0] value, [35:32] index, zero padding above.
    input  wire logic [sas_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // [1:0] kind.
    input  wire logic [sas_pkg::KIND_W-1:0]          s_axis_tuser,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // [31:0] read_value, [36:32] count, zero padding above.
    output logic [sas_pkg::OUT_TDATA_W-1:0]          m_axis_tdata,
    // [1:0] status.
    output logic [sas_pkg::STATUS_W-1:0]             m_axis_tuser,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [sas_pkg::CAP_W-1:0]           cfg_data
);

    sas_pkg::sas_cmd_t                  cmd;
    logic [sas_pkg::VALUE_W-1:0]        res_read_value;
    logic [sas_pkg::STATUS_W-1:0]       res_status;
    logic [sas_pkg::COUNT_W-1:0]        res_count;

    sas_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cfg_valid (cfg_valid),
        .cmd       (cmd)
    );

    sas_datapath #(
        .DEPTH      (DEPTH),
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .in_kind        (s_axis_tuser),
        .in_value       (s_axis_tdata[sas_pkg::VALUE_W-1:0]),
        .in_index       (s_axis_tdata[sas_pkg::VALUE_W +: sas_pkg::INDEX_W]),
        .cfg_capacity   (cfg_data),
        .res_read_value (res_read_value),
        .res_status     (res_status),
        .res_count      (res_count)
    );

    assign cfg_ready    = 1'b1;
    assign m_axis_tuser = res_status;
    assign m_axis_tdata = {
        {(sas_pkg::OUT_TDATA_W - sas_pkg::VALUE_W - sas_pkg::COUNT_W){1'b0}},
        res_count,
        res_read_value
    };

endmodule

`default_nettype wire

/* tb/sv/tb_sorted_array_store_top.sv */
`timescale 1ns / 100ps

module tb_sorted_array_store_top;
    import sas_pkg::*;

    localparam int DEPTH        = 16;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int REPORT_LIMIT = 10;
    localparam int PHASE_OPS    = 244;

    localparam logic [KIND_W-1:0] KIND_NOP = 2'd3;

    typedef struct {
        logic [KIND_W-1:0]  kind;
        logic [VALUE_W-1:0] value;
        logic [INDEX_W-1:0] index;
        bit                 drain;
    } store_op_t;

    typedef struct packed {
        logic [VALUE_W-1:0]  read_value;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  count;
    } store_result_t;

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic [KIND_W-1:0]      s_axis_tuser  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [STATUS_W-1:0]    m_axis_tuser;
    logic                   cfg_valid     = 1'b0;
    logic                   cfg_ready;
    logic [CAP_W-1:0]       cfg_data      = '0;

    logic [VALUE_W-1:0] store_model [DEPTH];
    int                 stored_count = 0;
    logic [CAP_W-1:0]   cap_setting  = CAP_RESET;
    int                 plan_count   = 0;
    logic [CAP_W-1:0]   plan_cap     = CAP_RESET;

    store_op_t     pending_ops [$];
    store_result_t predicted_results [$];
    store_op_t     offered_op;
    store_result_t seen_result;
    store_result_t wanted_result;

    bit calm      = 1'b0;
    int send_gap  = 0;
    int recv_gap  = 0;

    int cycle_count     = 0;
    int fault_count     = 0;
    int results_checked = 0;
    int insert_ops      = 0;
    int delete_ops      = 0;
    int read_ops        = 0;
    int nop_ops         = 0;
    int full_drops      = 0;
    int range_errors    = 0;
    int cap_writes      = 0;

    always #5 clk = ~clk;

    always @(posedge clk) cycle_count <= cycle_count + 1;

    sorted_array_store_top #(
        .DEPTH      (DEPTH),
        .VALUE_BITS (VALUE_W)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    function automatic int effective_cap(input logic [CAP_W-1:0] cap);
        if (cap == 0)
            return 1;
        if (cap > DEPTH)
            return DEPTH;
        return int'(cap);
    endfunction

    function automatic int draw_gap();
        if (calm)
            return 0;
        return $urandom_range(0, 3);
    endfunction

    function automatic store_result_t apply_operation(input store_op_t op);
        store_result_t res;
        int            pos;
        res = '0;
        case (op.kind)
            KIND_INSERT:
            begin
                insert_ops++;
                if (stored_count >= effective_cap(cap_setting))
                begin
                    res.status = ST_FULL;
                    full_drops++;
                end
                else
                begin
                    pos = 0;
                    while (pos < stored_count && !(op.value < store_model[pos]))
                        pos++;
                    for (int i = stored_count; i > pos; i--)
                        store_model[i] = store_model[i-1];
                    store_model[pos] = op.value;
                    stored_count++;
                end
            end
            KIND_DELETE:
            begin
                delete_ops++;
                if (op.index >= stored_count)
                begin
                    res.status = ST_RANGE;
                    range_errors++;
                end
                else
                begin
                    for (int i = op.index; i + 1 < stored_count; i++)
                        store_model[i] = store_model[i+1];
                    stored_count--;
                end
            end
            KIND_READ:
            begin
                read_ops++;
                if (op.index < stored_count)
                    res.read_value = store_model[op.index];
                else
                begin
                    res.status = ST_RANGE;
                    range_errors++;
                end
            end
            default:
                nop_ops++;
        endcase
        res.count = COUNT_W'(stored_count);
        return res;
    endfunction

    function automatic void plan_op(input logic [KIND_W-1:0] kind,
                                    input logic [VALUE_W-1:0] value,
                                    input logic [INDEX_W-1:0] index,
                                    input bit drain);
        store_op_t op;
        op.kind  = kind;
        op.value = value;
        op.index = index;
        op.drain = drain;
        pending_ops.push_back(op);
        if (kind == KIND_INSERT && plan_count < effective_cap(plan_cap))
            plan_count++;
        else if (kind == KIND_DELETE && index < plan_count)
            plan_count--;
    endfunction

    function automatic logic [VALUE_W-1:0] random_value();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3:    return VALUE_W'($urandom_range(0, 7));
            default: return VALUE_W'($urandom);
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                predicted_results.push_back(apply_operation(offered_op));
                send_gap = draw_gap();
            end
            if (s_axis_tvalid && !s_axis_tready)
            begin
                s_axis_tvalid <= 1'b1;
            end
            else if (send_gap > 0)
            begin
                send_gap--;
                s_axis_tvalid <= 1'b0;
            end
            else if (pending_ops.size() > 0 &&
                     !(pending_ops[0].drain && predicted_results.size() > 0))
            begin
                offered_op = pending_ops.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {{(IN_TDATA_W-INDEX_W-VALUE_W){1'b0}},
                                  offered_op.index, offered_op.value};
                s_axis_tuser  <= offered_op.kind;
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            recv_gap = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                seen_result.read_value = m_axis_tdata[VALUE_W-1:0];
                seen_result.count      = m_axis_tdata[VALUE_W+COUNT_W-1:VALUE_W];
                seen_result.status     = m_axis_tuser;
                if (predicted_results.size() == 0)
                begin
                    if (fault_count < REPORT_LIMIT)
                        $display("Unexpected result: value %h status %0d count %0d",
                                 seen_result.read_value, seen_result.status,
                                 seen_result.count);
                    fault_count++;
                end
                else
                begin
                    wanted_result = predicted_results.pop_front();
                    if (seen_result.read_value !== wanted_result.read_value ||
                        seen_result.status !== wanted_result.status ||
                        seen_result.count !== wanted_result.count)
                    begin
                        if (fault_count < REPORT_LIMIT)
                            $display({"Mismatch on result %0d: expected value %h status %0d",
                                      " count %0d, got value %h status %0d count %0d"},
                                     results_checked, wanted_result.read_value,
                                     wanted_result.status, wanted_result.count,
                                     seen_result.read_value, seen_result.status,
                                     seen_result.count);
                        fault_count++;
                    end
                    results_checked++;
                end
                recv_gap = draw_gap();
            end
            if (recv_gap > 0)
            begin
                recv_gap--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic wait_for_idle();
        while (pending_ops.size() > 0 || s_axis_tvalid || predicted_results.size() > 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        wait_for_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= cap;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid   <= 1'b0;
        cap_setting = cap;
        plan_cap    = cap;
        cap_writes++;
    endtask

    task automatic run_random_phase(input int n_ops, input bit quiet);
        int                 insert_pct;
        int                 pick;
        logic [KIND_W-1:0]  kind;
        logic [INDEX_W-1:0] index;
        calm = quiet;
        insert_pct = $urandom_range(30, 70);
        for (int k = 0; k < n_ops; k++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < insert_pct)
                kind = KIND_INSERT;
            else if (pick >= 96)
                kind = KIND_NOP;
            else if (pick % 2 == 0)
                kind = KIND_DELETE;
            else
                kind = KIND_READ;
            if (plan_count > 0 && $urandom_range(0, 4) != 0)
                index = INDEX_W'($urandom_range(0, plan_count - 1));
            else
                index = INDEX_W'($urandom_range(0, DEPTH - 1));
            plan_op(kind, random_value(), index, $urandom_range(0, 99) == 0);
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Empty store, reset capacity, extremes of value and index.
        plan_op(KIND_READ,   '1,           4'd0,  1'b0);
        plan_op(KIND_DELETE, '1,           4'd0,  1'b0);
        plan_op(KIND_NOP,    32'hA5A55A5A, 4'hF,  1'b0);
        plan_op(KIND_INSERT, '1,           4'hF,  1'b0);
        plan_op(KIND_INSERT, '0,           4'd0,  1'b0);
        plan_op(KIND_INSERT, 32'd5,        4'd0,  1'b0);
        plan_op(KIND_INSERT, 32'd5,        4'd0,  1'b1);
        plan_op(KIND_READ,   '0,           4'd0,  1'b0);
        plan_op(KIND_READ,   '0,           4'd2,  1'b0);
        plan_op(KIND_READ,   '0,           4'd3,  1'b0);
        plan_op(KIND_READ,   '0,           4'hF,  1'b0);
        plan_op(KIND_DELETE, '0,           4'd3,  1'b0);
        plan_op(KIND_DELETE, '0,           4'd0,  1'b0);
        plan_op(KIND_DELETE, '0,           4'hF,  1'b0);

        // Capacity below the current count.
        write_capacity(5'd1);
        plan_op(KIND_INSERT, 32'd9,        4'd0,  1'b0);
        plan_op(KIND_READ,   '0,           4'd1,  1'b0);
        plan_op(KIND_DELETE, '0,           4'd1,  1'b0);
        plan_op(KIND_INSERT, 32'd9,        4'd0,  1'b0);
        plan_op(KIND_DELETE, '0,           4'd0,  1'b0);
        plan_op(KIND_INSERT, 32'd9,        4'd0,  1'b0);
        plan_op(KIND_INSERT, 32'd3,        4'd0,  1'b0);

        // A capacity of zero behaves as one.
        write_capacity(5'd0);
        plan_op(KIND_INSERT, 32'd4,        4'd0,  1'b0);
        plan_op(KIND_DELETE, '0,           4'd0,  1'b0);
        plan_op(KIND_INSERT, 32'd4,        4'd0,  1'b0);
        plan_op(KIND_INSERT, 32'd4,        4'd0,  1'b0);

        write_capacity(5'd31);
        run_random_phase(PHASE_OPS, 1'b0);
        write_capacity(5'd16);
        run_random_phase(PHASE_OPS, 1'b0);
        write_capacity(5'd1);
        run_random_phase(PHASE_OPS, 1'b1);
        write_capacity(5'd8);
        run_random_phase(PHASE_OPS, 1'b0);
        write_capacity(CAP_W'($urandom_range(1, 16)));
        run_random_phase(PHASE_OPS, 1'b0);
        write_capacity(5'd0);
        run_random_phase(PHASE_OPS, 1'b1);
        write_capacity(CAP_W'($urandom_range(0, 31)));
        run_random_phase(PHASE_OPS, 1'b0);
        write_capacity(5'd16);
        run_random_phase(PHASE_OPS, 1'b0);

        wait_for_idle();
        repeat (8) @(posedge clk);
        $display("Run covered %0d inserts, %0d deletes, %0d reads and %0d unused kinds over %0d capacity writes.",
                 insert_ops, delete_ops, read_ops, nop_ops, cap_writes);
        $display("Checked %0d results, with %0d inserts dropped on a full store and %0d indexes out of range.",
                 results_checked, full_drops, range_errors);
        if (fault_count == 0 && predicted_results.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("Timeout after %0d cycles with %0d results outstanding.",
                 cycle_count, predicted_results.size());
        $display("FAILED: results differ");
        $finish;
    end

endmodule
